@@ src/bug_pkg.sv @@
`default_nettype none

package bug_pkg;

  localparam int SAMPLE_COUNT = 8;
  localparam int SAMPLE_W     = 12;
  localparam int MV_W         = 16;
  localparam int TICKS_W      = 8;
  localparam int SUM_W        = SAMPLE_W + $clog2(SAMPLE_COUNT);
  // avg * 33300 + 2047 stays below 2^28
  localparam int PROD_W       = 28;
  localparam int ADDR_W       = 4;
  localparam int DATA_W       = 32;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [MV_W-1:0]     mv_t;
  typedef logic [TICKS_W-1:0]  ticks_t;
  typedef sample_t [SAMPLE_COUNT-1:0] sample_vec_t;

  localparam mv_t     MV_FULL_SCALE = 16'd33300;
  localparam sample_t MV_ROUND      = 12'd2047;
  localparam sample_t ADC_FULL      = 12'd4095;

  localparam mv_t    STOP_RESET   = 16'd22000;
  localparam mv_t    RESUME_RESET = 16'd23000;
  localparam ticks_t PERIOD_RESET = 8'd50;

  localparam logic [1:0] REG_STOP   = 2'd0;
  localparam logic [1:0] REG_RESUME = 2'd1;
  localparam logic [1:0] REG_PERIOD = 2'd2;

  typedef struct packed {
    mv_t    stop;
    mv_t    resume;
    ticks_t period;
  } cfg_t;

  typedef struct packed {
    logic    valid;
    sample_t avg;
    mv_t     mv;
  } meas_t;

  typedef struct packed {
    logic    valid;
    logic    low_voltage;
    logic    measured;
    sample_t average_raw;
    mv_t     battery_millivolts;
  } res_t;

endpackage

`default_nettype wire

@@ src/bug_ifs.sv @@
`default_nettype none

interface bug_in_if;
  logic             valid;
  logic             ready;
  bug_pkg::sample_t sample_0;
  bug_pkg::sample_t sample_1;
  bug_pkg::sample_t sample_2;
  bug_pkg::sample_t sample_3;
  bug_pkg::sample_t sample_4;
  bug_pkg::sample_t sample_5;
  bug_pkg::sample_t sample_6;
  bug_pkg::sample_t sample_7;

  modport source (output valid, sample_0, sample_1, sample_2, sample_3,
                  sample_4, sample_5, sample_6, sample_7, input ready);
  modport sink   (input valid, sample_0, sample_1, sample_2, sample_3,
                  sample_4, sample_5, sample_6, sample_7, output ready);
endinterface

interface bug_out_if;
  logic             valid;
  logic             ready;
  logic             low_voltage;
  logic             measured;
  bug_pkg::sample_t average_raw;
  bug_pkg::mv_t     battery_millivolts;

  modport source (output valid, low_voltage, measured, average_raw,
                  battery_millivolts, input ready);
  modport sink   (input valid, low_voltage, measured, average_raw,
                  battery_millivolts, output ready);
endinterface

`default_nettype wire

@@ src/bug_cfg_regs.sv @@
`default_nettype none

module bug_cfg_regs (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [bug_pkg::ADDR_W-1:0] paddr,
  input  wire logic [bug_pkg::DATA_W-1:0] pwdata,
  output logic      [bug_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output bug_pkg::cfg_t                   cfg
);

  bug_pkg::cfg_t cfg_r;
  logic [1:0]    idx;
  logic          wr_en;

  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stop   <= bug_pkg::STOP_RESET;
      cfg_r.resume <= bug_pkg::RESUME_RESET;
      cfg_r.period <= bug_pkg::PERIOD_RESET;
    end else if (wr_en) begin
      unique case (idx)
        bug_pkg::REG_STOP:   cfg_r.stop   <= pwdata[bug_pkg::MV_W-1:0];
        bug_pkg::REG_RESUME: cfg_r.resume <= pwdata[bug_pkg::MV_W-1:0];
        bug_pkg::REG_PERIOD: cfg_r.period <= pwdata[bug_pkg::TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      bug_pkg::REG_STOP:   prdata = bug_pkg::DATA_W'(cfg_r.stop);
      bug_pkg::REG_RESUME: prdata = bug_pkg::DATA_W'(cfg_r.resume);
      bug_pkg::REG_PERIOD: prdata = bug_pkg::DATA_W'(cfg_r.period);
      default:             prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ src/bug_scale.sv @@
`default_nettype none

module bug_scale (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 adv,
  input  wire logic                 in_valid,
  input  wire bug_pkg::sample_vec_t samples,
  output bug_pkg::meas_t            meas
);

  // stage 1: input register
  logic                 v1_r;
  bug_pkg::sample_vec_t smp1_r;
  // stage 2: average
  logic                 v2_r;
  bug_pkg::sample_t     avg2_r;
  // stage 3: scaled product
  logic                       v3_r;
  bug_pkg::sample_t           avg3_r;
  logic [bug_pkg::PROD_W-1:0] prod3_r;
  // stage 4: quotient estimate
  logic                       v4_r;
  bug_pkg::sample_t           avg4_r;
  logic [bug_pkg::PROD_W-1:0] prod4_r;
  bug_pkg::mv_t               q4_r;
  // stage 5: corrected quotient
  bug_pkg::meas_t             meas_r;

  logic [bug_pkg::SUM_W-1:0]  sum;
  logic [bug_pkg::PROD_W:0]   est;
  logic [bug_pkg::PROD_W-1:0] back;
  logic [bug_pkg::PROD_W-1:0] rem;
  bug_pkg::mv_t               q_fix;

  always_comb begin
    sum = '0;
    for (int i = 0; i < bug_pkg::SAMPLE_COUNT; i++) begin
      sum = sum + bug_pkg::SUM_W'(smp1_r[i]);
    end
  end

  // x/4095 ~ (x + x/4096 + x/4096^2)/4096, low by at most one
  assign est = (bug_pkg::PROD_W+1)'(prod3_r)
             + (bug_pkg::PROD_W+1)'(prod3_r >> 12)
             + (bug_pkg::PROD_W+1)'(prod3_r >> 24);

  assign back  = {q4_r, 12'b0} - bug_pkg::PROD_W'(q4_r);
  assign rem   = prod4_r - back;
  assign q_fix = (rem >= bug_pkg::PROD_W'(bug_pkg::ADC_FULL)) ? q4_r + 16'd1 : q4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      v4_r         <= 1'b0;
      meas_r.valid <= 1'b0;
    end else if (adv) begin
      v1_r         <= in_valid;
      v2_r         <= v1_r;
      v3_r         <= v2_r;
      v4_r         <= v3_r;
      meas_r.valid <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      smp1_r      <= samples;
      avg2_r      <= sum[bug_pkg::SUM_W-1:bug_pkg::SUM_W-bug_pkg::SAMPLE_W];
      avg3_r      <= avg2_r;
      prod3_r     <= bug_pkg::PROD_W'(avg2_r) * bug_pkg::PROD_W'(bug_pkg::MV_FULL_SCALE)
                   + bug_pkg::PROD_W'(bug_pkg::MV_ROUND);
      avg4_r      <= avg3_r;
      prod4_r     <= prod3_r;
      q4_r        <= est[bug_pkg::PROD_W-1:12];
      meas_r.avg  <= avg4_r;
      meas_r.mv   <= q_fix;
    end
  end

  assign meas = meas_r;

endmodule

`default_nettype wire

@@ src/bug_guard.sv @@
`default_nettype none

module bug_guard (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           adv,
  input  wire bug_pkg::meas_t meas,
  input  wire bug_pkg::cfg_t  cfg,
  output bug_pkg::res_t       res
);

  bug_pkg::ticks_t  cnt_r;
  logic             low_r;
  bug_pkg::sample_t avg_r;
  bug_pkg::mv_t     mv_r;
  logic             valid_r;
  logic             measured_r;

  bug_pkg::ticks_t  cnt_inc;
  logic             take;

  assign cnt_inc = cnt_r + 8'd1;
  assign take    = !(cnt_inc < cfg.period);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cnt_r   <= '0;
      low_r   <= 1'b0;
      avg_r   <= '0;
      mv_r    <= '0;
    end else if (adv) begin
      valid_r <= meas.valid;
      if (meas.valid) begin
        if (take) begin
          cnt_r <= '0;
          avg_r <= meas.avg;
          mv_r  <= meas.mv;
          if (!low_r && (meas.mv < cfg.stop)) begin
            low_r <= 1'b1;
          end else if (low_r && (meas.mv > cfg.resume)) begin
            low_r <= 1'b0;
          end
        end else begin
          cnt_r <= cnt_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && meas.valid) begin
      measured_r <= take;
    end
  end

  assign res.valid              = valid_r;
  assign res.low_voltage        = low_r;
  assign res.measured           = measured_r;
  assign res.average_raw        = avg_r;
  assign res.battery_millivolts = mv_r;

endmodule

`default_nettype wire

@@ src/battery_undervoltage_guard.sv @@
`default_nettype none

// Battery undervoltage guard. One request is one timer tick with eight ADC samples; every
// request gives exactly one result, in order. Unless stalled, throughput is one tick per
// clock; a result appears once its request has passed a six-register chain (input
// register, average, scale multiply, reciprocal estimate, quotient correction, guard state
// and result register). The whole chain stalls while a result waits on out_ch. The tick
// counter and hysteresis flag live in the last stage, so each tick sees the state left by
// the one before it. Registers sit at byte addresses 0 (stop level), 4 (resume level) and
// 8 (sample period) and should be written only while no tick is in flight.
module battery_undervoltage_guard (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  bug_in_if.sink                          in_ch,
  bug_out_if.source                       out_ch,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [bug_pkg::ADDR_W-1:0] paddr,
  input  wire logic [bug_pkg::DATA_W-1:0] pwdata,
  output logic      [bug_pkg::DATA_W-1:0] prdata,
  output logic                            pready
);

  bug_pkg::cfg_t        cfg;
  bug_pkg::meas_t       meas;
  bug_pkg::res_t        res;
  bug_pkg::sample_vec_t samples;
  logic                 adv;

  assign adv         = !(res.valid && !out_ch.ready);
  assign in_ch.ready = adv;

  assign samples[0] = in_ch.sample_0;
  assign samples[1] = in_ch.sample_1;
  assign samples[2] = in_ch.sample_2;
  assign samples[3] = in_ch.sample_3;
  assign samples[4] = in_ch.sample_4;
  assign samples[5] = in_ch.sample_5;
  assign samples[6] = in_ch.sample_6;
  assign samples[7] = in_ch.sample_7;

  bug_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bug_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_ch.valid),
    .samples  (samples),
    .meas     (meas)
  );

  bug_guard u_guard (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .meas  (meas),
    .cfg   (cfg),
    .res   (res)
  );

  assign out_ch.valid              = res.valid;
  assign out_ch.low_voltage        = res.low_voltage;
  assign out_ch.measured           = res.measured;
  assign out_ch.average_raw        = res.average_raw;
  assign out_ch.battery_millivolts = res.battery_millivolts;

  // a held result freezes the chain, so no new request may be taken
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
    else $error("request taken while result stalled");

  a_mv_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.battery_millivolts <= bug_pkg::MV_FULL_SCALE))
    else $error("millivolt value out of range");

  a_meas_mv_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    meas.valid |-> (meas.mv <= bug_pkg::MV_FULL_SCALE))
    else $error("scaled quotient out of range");

endmodule

`default_nettype wire
